>>> rtl/nab_pkg.sv
// Shared types and constants for the node allocation bitmap.
`default_nettype none
package nab_pkg;

  localparam int NODE_W = 6;
  localparam int CNT_W  = 7;
  localparam int CMD_W  = 3;
  localparam int ERR_W  = 2;
  localparam int QDEPTH = 2;

  // Command codes as they arrive on the request channel.
  localparam logic [CMD_W-1:0] CMD_ALLOC     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEALLOC   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LIST_FREE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LIST_USED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RESET     = 3'd4;

  // Error codes reported with each result.
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BUSY  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_IDLE  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd3;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_DEALLOC,
    OP_LIST_FREE,
    OP_LIST_USED,
    OP_RESET
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NODE_W-1:0] node;
  } req_t;

  typedef enum logic [0:0] {
    BK_IDLE,
    BK_SCAN
  } bk_state_t;

endpackage
`default_nettype wire

>>> rtl/node_allocation_bitmap_core.sv
// Top level of the node allocation bitmap: front end, request queue and back end.
`default_nettype none
//
//  Channel   Direction  Handshake          Carries
//  in_*      in         in_valid/in_stall  in_cmd, in_node_index
//  out_*     out        out_valid/out_stall node_out, node_valid, last, error_code,
//                                          free_count
//  cfg_*     in         cfg_valid/cfg_ready active_nodes write data (cfg_data)
//
//  The front end takes one request per cycle into a two-entry queue and stalls
//  only while that queue is full. Allocate, deallocate and reset are each handled
//  from the back end's idle state. A list request with matches enters the scan
//  state and steps through the nodes from node 0 up to the last matching node,
//  emitting one result per matching node; an empty list emits a single result
//  from the idle state. Reset (rst_n low at a clock edge) frees every node and sets
//  active_nodes to MAX_NODES. A stalled result holds in the output register and the
//  back end waits, while the queue keeps filling.
//
module node_allocation_bitmap_core #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [nab_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [nab_pkg::NODE_W-1:0]   in_node_index,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [nab_pkg::NODE_W-1:0]        out_node_out,
  output logic                              out_node_valid,
  output logic                              out_last,
  output logic [nab_pkg::ERR_W-1:0]         out_error_code,
  output logic [nab_pkg::CNT_W-1:0]         out_free_count,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [nab_pkg::CNT_W-1:0]    cfg_data
);
  import nab_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_not_empty;
  req_t q_wdata;
  req_t q_rdata;

  // Writes to active_nodes must arrive only while the block is idle; the user is bound,
  // the block does not enforce it, and the port is always ready. A write also frees every node.
  assign cfg_ready = 1'b1;

  nab_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_node_index (in_node_index),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // The queue decouples request acceptance from the multi-cycle list scans.
  nab_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  // The back end owns the bitmap, the free count and the result register.
  nab_back #(
    .MAX_NODES (MAX_NODES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .q_valid        (q_not_empty),
    .q_req          (q_rdata),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_node_out   (out_node_out),
    .out_node_valid (out_node_valid),
    .out_last       (out_last),
    .out_error_code (out_error_code),
    .out_free_count (out_free_count)
  );

endmodule
`default_nettype wire

>>> rtl/nab_front.sv
// Request front end: accepts requests, decodes commands and drops unknown ones.
`default_nettype none
module nab_front (
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [nab_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [nab_pkg::NODE_W-1:0]   in_node_index,
  input  wire logic                         q_full,
  output logic                              q_push,
  output nab_pkg::req_t                     q_wdata
);
  import nab_pkg::*;

  logic known;
  op_t  op;

  always_comb begin
    known = 1'b1;
    op    = OP_ALLOC;
    case (in_cmd)
      CMD_ALLOC:     op = OP_ALLOC;
      CMD_DEALLOC:   op = OP_DEALLOC;
      CMD_LIST_FREE: op = OP_LIST_FREE;
      CMD_LIST_USED: op = OP_LIST_USED;
      CMD_RESET:     op = OP_RESET;
      default:       known = 1'b0;
    endcase
  end

  // Unknown commands are accepted and discarded without a result.
  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full && known;
  assign q_wdata.op   = op;
  assign q_wdata.node = in_node_index;

endmodule
`default_nettype wire

>>> rtl/nab_queue.sv
// Short request queue between the front end and the execution back end.
`default_nettype none
module nab_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire nab_pkg::req_t wdata,
  input  wire logic          pop,
  output logic               full,
  output logic               not_empty,
  output nab_pkg::req_t      rdata
);
  import nab_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_QW = $clog2(QDEPTH + 1);

  req_t              mem_r [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;
  logic              do_pop;

  assign full      = (count_r == CNT_QW'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = mem_r[rd_ptr_r];
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

>>> rtl/nab_back.sv
// Execution back end: bitmap, free count, list scanner and result register.
`default_nettype none
module nab_back #(
  parameter int MAX_NODES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_valid,
  input  wire logic [nab_pkg::CNT_W-1:0]    cfg_data,
  input  wire logic                         q_valid,
  input  wire nab_pkg::req_t                q_req,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [nab_pkg::NODE_W-1:0]        out_node_out,
  output logic                              out_node_valid,
  output logic                              out_last,
  output logic [nab_pkg::ERR_W-1:0]         out_error_code,
  output logic [nab_pkg::CNT_W-1:0]         out_free_count
);
  import nab_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);

  bk_state_t             state_r, state_nxt;
  logic [IDX_W-1:0]      scan_r, scan_nxt;
  logic [MAX_NODES-1:0]  free_map_r, free_map_nxt;
  logic [CNT_W-1:0]      free_total_r, free_total_nxt;
  logic [CNT_W-1:0]      active_r, active_nxt;

  logic                  out_valid_r;
  logic [NODE_W-1:0]     out_node_r;
  logic                  out_node_valid_r;
  logic                  out_last_r;
  logic [ERR_W-1:0]      out_err_r;
  logic [CNT_W-1:0]      out_free_r;

  logic                  out_free;
  logic [CNT_W-1:0]      cfg_clamped;
  logic [MAX_NODES-1:0]  act_mask;
  logic [MAX_NODES-1:0]  later_mask;
  logic [MAX_NODES-1:0]  match_vec;
  logic                  in_range;
  logic                  node_is_free;
  logic [IDX_W-1:0]      node_idx;

  logic                  emit;
  logic [NODE_W-1:0]     e_node;
  logic                  e_valid;
  logic                  e_last;
  logic [ERR_W-1:0]      e_err;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = CNT_W'(1);
    end else if (cfg_data > MAX_CNT) begin
      cfg_clamped = MAX_CNT;
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      act_mask[i]   = (CNT_W'(i) < active_r);
      later_mask[i] = (IDX_W'(i) > scan_r);
    end
  end

  assign match_vec = ((q_req.op == OP_LIST_FREE) ? free_map_r : ~free_map_r) & act_mask;

  assign in_range     = ({1'b0, q_req.node} < active_r);
  assign node_idx     = q_req.node[IDX_W-1:0];
  assign node_is_free = in_range ? free_map_r[node_idx] : 1'b0;

  always_comb begin
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    free_map_nxt   = free_map_r;
    free_total_nxt = free_total_r;
    active_nxt     = active_r;
    q_pop          = 1'b0;
    emit           = 1'b0;
    e_node         = '0;
    e_valid        = 1'b0;
    e_last         = 1'b1;
    e_err          = ERR_OK;
    if (cfg_valid) begin
      active_nxt     = cfg_clamped;
      free_map_nxt   = '1;
      free_total_nxt = cfg_clamped;
    end else begin
      case (state_r)
        BK_IDLE: begin
          if (q_valid && out_free) begin
            case (q_req.op)
              OP_ALLOC, OP_DEALLOC: begin
                emit   = 1'b1;
                q_pop  = 1'b1;
                e_node = q_req.node;
                if (!in_range) begin
                  e_err = ERR_RANGE;
                end else if (q_req.op == OP_ALLOC && !node_is_free) begin
                  e_err = ERR_BUSY;
                end else if (q_req.op == OP_DEALLOC && node_is_free) begin
                  e_err = ERR_IDLE;
                end
                if (e_err == ERR_OK) begin
                  e_valid = 1'b1;
                  if (q_req.op == OP_ALLOC) begin
                    free_map_nxt[node_idx] = 1'b0;
                    if (free_total_r != '0) begin
                      free_total_nxt = free_total_r - 1'b1;
                    end
                  end else begin
                    free_map_nxt[node_idx] = 1'b1;
                    if (free_total_r < active_r) begin
                      free_total_nxt = free_total_r + 1'b1;
                    end
                  end
                end
              end
              OP_LIST_FREE, OP_LIST_USED: begin
                if (match_vec == '0) begin
                  emit  = 1'b1;
                  q_pop = 1'b1;
                end else begin
                  state_nxt = BK_SCAN;
                  scan_nxt  = '0;
                end
              end
              OP_RESET: begin
                emit           = 1'b1;
                q_pop          = 1'b1;
                free_map_nxt   = '1;
                free_total_nxt = active_r;
              end
              default: begin
                q_pop = 1'b1;
              end
            endcase
          end
        end
        BK_SCAN: begin
          if (!match_vec[scan_r]) begin
            scan_nxt = scan_r + 1'b1;
          end else if (out_free) begin
            emit    = 1'b1;
            e_node  = NODE_W'(scan_r);
            e_valid = 1'b1;
            e_last  = ((match_vec & later_mask) == '0);
            if (e_last) begin
              q_pop     = 1'b1;
              state_nxt = BK_IDLE;
            end else begin
              scan_nxt = scan_r + 1'b1;
            end
          end
        end
        default: begin
          state_nxt = BK_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      scan_r       <= '0;
      free_map_r   <= '1;
      free_total_r <= MAX_CNT;
      active_r     <= MAX_CNT;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      free_map_r   <= free_map_nxt;
      free_total_r <= free_total_nxt;
      active_r     <= active_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_node_r       <= e_node;
      out_node_valid_r <= e_valid;
      out_last_r       <= e_last;
      out_err_r        <= e_err;
      out_free_r       <= free_total_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_node_out   = out_node_r;
  assign out_node_valid = out_node_valid_r;
  assign out_last       = out_last_r;
  assign out_error_code = out_err_r;
  assign out_free_count = out_free_r;

endmodule
`default_nettype wire

>>> tb/sv/nab_checker.sv
// Scoreboard for the node allocation bitmap: predicts each request's results and compares them.
`timescale 1ns / 100ps

module nab_checker #(
  parameter int MAX_NODES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [nab_pkg::CMD_W-1:0]  in_cmd,
  input  logic [nab_pkg::NODE_W-1:0] in_node_index,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [nab_pkg::NODE_W-1:0] out_node_out,
  input  logic                       out_node_valid,
  input  logic                       out_last,
  input  logic [nab_pkg::ERR_W-1:0]  out_error_code,
  input  logic [nab_pkg::CNT_W-1:0]  out_free_count,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [nab_pkg::CNT_W-1:0]  cfg_data,
  output int                         mismatch_count,
  output int                         pending
);
  import nab_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              node_valid;
    logic              last;
    logic [ERR_W-1:0]  err;
    logic [CNT_W-1:0]  free_cnt;
  } node_result_t;

  logic [MAX_NODES-1:0] free_map;
  logic [CNT_W-1:0]     free_total;
  logic [CNT_W-1:0]     active_nodes;
  node_result_t         expected_results[$];

  function automatic node_result_t make_result(input logic [NODE_W-1:0] node,
                                               input logic valid, input logic last,
                                               input logic [ERR_W-1:0] err);
    node_result_t r;
    r.node       = node;
    r.node_valid = valid;
    r.last       = last;
    r.err        = err;
    r.free_cnt   = free_total;
    return r;
  endfunction

  task automatic free_all_nodes();
    free_map   = '1;
    free_total = active_nodes;
  endtask

  // A register write clamps into 1..MAX_NODES and frees the whole machine.
  task automatic apply_active_nodes(input logic [CNT_W-1:0] value);
    if (value == 0) begin
      active_nodes = CNT_W'(1);
    end else if (value > MAX_NODES) begin
      active_nodes = CNT_W'(MAX_NODES);
    end else begin
      active_nodes = value;
    end
    free_all_nodes();
  endtask

  task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] idx);
    logic [ERR_W-1:0] err;
    logic             want_free;
    int               hits;
    int               last_hit;
    case (cmd)
      CMD_ALLOC, CMD_DEALLOC: begin
        // The range check wins over the busy and idle checks.
        err = ERR_OK;
        if (idx >= active_nodes) begin
          err = ERR_RANGE;
        end else if (cmd == CMD_ALLOC && !free_map[idx]) begin
          err = ERR_BUSY;
        end else if (cmd == CMD_DEALLOC && free_map[idx]) begin
          err = ERR_IDLE;
        end
        if (err == ERR_OK) begin
          if (cmd == CMD_ALLOC) begin
            free_map[idx] = 1'b0;
            if (free_total > 0) free_total--;
          end else begin
            free_map[idx] = 1'b1;
            if (free_total < active_nodes) free_total++;
          end
        end
        expected_results.push_back(make_result(idx, err == ERR_OK, 1'b1, err));
      end
      CMD_LIST_FREE, CMD_LIST_USED: begin
        want_free = (cmd == CMD_LIST_FREE);
        hits      = 0;
        last_hit  = 0;
        for (int i = 0; i < active_nodes; i++) begin
          if (free_map[i] == want_free) begin
            hits++;
            last_hit = i;
          end
        end
        if (hits == 0) begin
          expected_results.push_back(make_result('0, 1'b0, 1'b1, ERR_OK));
        end else begin
          for (int i = 0; i < active_nodes; i++) begin
            if (free_map[i] == want_free) begin
              expected_results.push_back(make_result(i[NODE_W-1:0], 1'b1,
                                                     i == last_hit, ERR_OK));
            end
          end
        end
      end
      CMD_RESET: begin
        free_all_nodes();
        expected_results.push_back(make_result('0, 1'b0, 1'b1, ERR_OK));
      end
      default: begin
        // Unused command codes are dropped without a result.
      end
    endcase
  endtask

  function automatic int check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    node_result_t exp_r;
    if (!rst_n) begin
      active_nodes = CNT_W'(MAX_NODES);
      free_all_nodes();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_active_nodes(cfg_data);
      if (in_valid && !in_stall) predict_request(in_cmd, in_node_index);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: node_out %0d, error_code %0d", out_node_out,
                 out_error_code);
          mismatch_count++;
        end else begin
          exp_r = expected_results.pop_front();
          mismatch_count += check_field("node_out", exp_r.node, out_node_out);
          mismatch_count += check_field("node_valid", exp_r.node_valid, out_node_valid);
          mismatch_count += check_field("last", exp_r.last, out_last);
          mismatch_count += check_field("error_code", exp_r.err, out_error_code);
          mismatch_count += check_field("free_count", exp_r.free_cnt, out_free_count);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> tb/sv/tb_node_allocation_bitmap_core.sv
// Testbench top for the node allocation bitmap: clock, reset, request traffic and verdict.
`timescale 1ns / 100ps

// The top only makes traffic. Every request, result and register write is
// watched by the scoreboard, which predicts the results of each accepted
// request and compares them field by field in order.
//
// The run starts with a directed part on the reset value of active_nodes,
// followed by a short directed part on a one-node machine, where the range
// error and the empty lists are easy to reach. After that come random phases,
// each one preceded by a register write: the extremes 1 and 64, a write of 0
// that must clamp to 1, a write of 127 that must clamp to 64, and some values
// in between. Before each write the block is allowed to drain completely.
module tb_node_allocation_bitmap_core;
  import nab_pkg::*;

  localparam int MAX_NODES    = 64;
  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 6;
  localparam int IDLE_PCT     = 31;
  localparam int PHASE_ITEMS  = 32;
  localparam int NUM_PHASES   = 9;
  localparam int CALM_PHASE   = 4;
  localparam int RANDOM_PHASE = 7;
  // The receiver's long hold-off starts once this many requests have gone in.
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 150;
  // Extra wait after the last result; unused command codes never enter the queue.
  localparam int DRAIN_CYCLES = 24;
  localparam int TIMEOUT_NS   = 2_000_000;

  localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [CMD_W-1:0]  in_cmd = '0;
  logic [NODE_W-1:0] in_node_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NODE_W-1:0] out_node_out;
  logic              out_node_valid;
  logic              out_last;
  logic [ERR_W-1:0]  out_error_code;
  logic [CNT_W-1:0]  out_free_count;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data = '0;

  int mismatch_count;
  int pending;
  int requests_sent = 0;
  // While set, neither side idles.
  bit calm = 1'b0;
  // Node count the block should be using now; it only shapes the random indices.
  int active_cfg = MAX_NODES;

  node_allocation_bitmap_core #(
    .MAX_NODES(MAX_NODES)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_node_index (in_node_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_node_out  (out_node_out),
    .out_node_valid(out_node_valid),
    .out_last      (out_last),
    .out_error_code(out_error_code),
    .out_free_count(out_free_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  nab_checker #(
    .MAX_NODES(MAX_NODES)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_node_index (in_node_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_node_out  (out_node_out),
    .out_node_valid(out_node_valid),
    .out_last      (out_last),
    .out_error_code(out_error_code),
    .out_free_count(out_free_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Offer one request, with random idle cycles in front of it, and hold it
  // until the block takes it. Valid stays high afterwards so that back-to-back
  // requests need no gap; a drain lowers it, and so does the next call when it idles.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] node);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_node_index <= node;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Stop offering requests and wait until every predicted result has come
  // out, then give the block time to swallow any request without a result.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The register write also frees every node, so it only happens when idle.
  task automatic write_active_nodes(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (value == 0) begin
      active_cfg = 1;
    end else if (value > MAX_NODES) begin
      active_cfg = MAX_NODES;
    end else begin
      active_cfg = value;
    end
  endtask

  // Mostly allocate and deallocate on nodes inside the machine, so that the
  // bitmap fills and empties; list requests, machine resets, indices past the
  // end of the machine and unused codes are mixed in.
  task automatic random_requests(input int count);
    int               pick;
    logic [CMD_W-1:0] cmd;
    logic [NODE_W-1:0] node;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        cmd = CMD_ALLOC;
      end else if (pick < 65) begin
        cmd = CMD_DEALLOC;
      end else if (pick < 77) begin
        cmd = CMD_LIST_FREE;
      end else if (pick < 90) begin
        cmd = CMD_LIST_USED;
      end else if (pick < 94) begin
        cmd = CMD_RESET;
      end else begin
        cmd = CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
      end
      if (active_cfg < MAX_NODES && $urandom_range(0, 9) == 0) begin
        node = NODE_W'($urandom_range(MAX_NODES - 1, active_cfg));
      end else begin
        node = NODE_W'($urandom_range(active_cfg - 1, 0));
      end
      send_request(cmd, node);
    end
  endtask

  // Receiver: random stalls, none at all while calm, and one long hold-off
  // early in the run so that the output register and the request queue fill
  // and the block has to stall its input.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && requests_sent >= HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int cfg_plan[NUM_PHASES];
    int cfg_value;

    cfg_plan = '{64, 1, 0, 2, 127, 17, 100, 0, 64};
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part on the reset value: both ends of the index range, a busy
    // allocate, an idle deallocate, non-empty and empty lists, a machine reset and
    // the unused command codes.
    send_request(CMD_ALLOC, 6'd0);
    send_request(CMD_ALLOC, 6'd63);
    send_request(CMD_ALLOC, 6'd0);
    send_request(CMD_DEALLOC, 6'd5);
    send_request(CMD_LIST_USED, 6'd63);
    send_request(CMD_LIST_FREE, 6'd0);
    send_request(CMD_DEALLOC, 6'd63);
    send_request(CMD_DEALLOC, 6'd0);
    send_request(CMD_LIST_USED, 6'd21);
    send_request(CMD_ALLOC, 6'd42);
    send_request(CMD_ALLOC, 6'd21);
    send_request(CMD_RESET, 6'd42);
    send_request(CMD_LIST_USED, 6'd0);
    send_request(CMD_UNUSED_LO, 6'd1);
    send_request(CMD_UNUSED_MID, 6'd2);
    send_request(CMD_UNUSED_HI, 6'd3);
    drain();

    // A one-node machine: indices past the end, and the list of free nodes
    // runs empty once node 0 is taken.
    write_active_nodes(7'd1);
    send_request(CMD_ALLOC, 6'd1);
    send_request(CMD_DEALLOC, 6'd63);
    send_request(CMD_ALLOC, 6'd0);
    send_request(CMD_LIST_FREE, 6'd0);
    send_request(CMD_LIST_USED, 6'd0);
    send_request(CMD_DEALLOC, 6'd0);
    send_request(CMD_DEALLOC, 6'd0);
    send_request(CMD_ALLOC, 6'd0);
    send_request(CMD_RESET, 6'd0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_value = (p == RANDOM_PHASE) ? $urandom_range(MAX_NODES - 1, 3) : cfg_plan[p];
      write_active_nodes(cfg_value[CNT_W-1:0]);
      calm = (p == CALM_PHASE);
      random_requests(PHASE_ITEMS);
      drain();
      calm = 1'b0;
    end

    if (mismatch_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
